// ----- rtl/fbc_pkg.sv -----
`default_nettype none

package fbc_pkg;

    // fixed point widths
    localparam int unsigned VAL_W   = 32;               // Q16.16 matrix and box values
    localparam int unsigned COEF_W  = VAL_W + 1;        // plane coefficient, sum or difference
    localparam int unsigned PROD_W  = COEF_W + VAL_W;   // exact coefficient times coordinate
    localparam int unsigned ACC_W   = PROD_W + 2;       // three products plus shifted d
    localparam int unsigned FRAC_W  = 16;               // fraction bits of Q16.16

    // geometry
    localparam int unsigned N_PLANES = 6;
    localparam int unsigned N_COEF   = 4;
    localparam int unsigned N_AXES   = 3;
    localparam int unsigned N_DIM    = 4;

    localparam int unsigned PLANE_W = 3;
    localparam int unsigned AXIS_W  = 3;
    localparam int unsigned IDX_W   = 2;

    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(N_PLANES - 1);
    localparam logic [IDX_W-1:0]   LAST_COL   = IDX_W'(N_DIM - 1);
    localparam logic [IDX_W-1:0]   W_ROW      = IDX_W'(N_DIM - 1);

    // per-plane step codes of the test sequence
    localparam logic [AXIS_W-1:0] STEP_X    = 3'd0;
    localparam logic [AXIS_W-1:0] STEP_Y    = 3'd1;
    localparam logic [AXIS_W-1:0] STEP_Z    = 3'd2;
    localparam logic [AXIS_W-1:0] STEP_D    = 3'd3;
    localparam logic [AXIS_W-1:0] STEP_LAST = 3'd4;

    // command codes
    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_REBUILD = 2'd1,
        FUNC_TEST    = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REBUILD,
        ST_TEST,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    // controls of the shared multiply-accumulate unit
    typedef struct packed {
        acc_op_t acc_op;
        logic    prod_d;     // pass d scaled to Q32.32 instead of a product
    } mac_ctrl_t;

    // controls of the matrix and plane store
    typedef struct packed {
        logic             mat_we;
        logic             plane_we;
        logic [IDX_W-1:0] rebuild_col;
    } store_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/frustum_box_cull_top.sv -----
// frustum_box_cull_top: view-frustum culling of axis-aligned boxes, Q16.16
//
// input channel (in_valid / in_stall) carries one command per beat:
//   func 0 loads matrix element (matrix_column, matrix_row) with matrix_value
//   func 1 rebuilds the six frustum planes from the matrix
//   func 2 tests the box given by box_min_* / box_max_*
// output channel (out_valid / out_stall) returns one beat per command;
// visible is 1 only for a tested box that lies inside or on every plane.
// a load or an unused code goes from ST_IDLE straight to ST_DONE; a
// rebuild runs ST_REBUILD first, a box test ST_TEST and ST_FINISH. a new
// command can be taken in the same cycle as the previous result shows.
// in a box test one shared multiplier runs 5 steps per plane (three
// products, the d term, a drain) over six planes; a rebuild walks the 4
// matrix columns one per cycle. while a command runs in_stall is high.
// a finished result waits in the output register while out_stall is high;
// the block still accepts the next command and holds its own result back
// until the output register frees up.
// reset clears the matrix and all planes to zero, so every box reads as
// visible until planes are rebuilt.

`default_nettype none

module frustum_box_cull_top
    import fbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic [IDX_W-1:0]        matrix_column,
    input  logic [IDX_W-1:0]        matrix_row,
    input  logic signed [VAL_W-1:0] matrix_value,
    input  logic signed [VAL_W-1:0] box_min_x,
    input  logic signed [VAL_W-1:0] box_min_y,
    input  logic signed [VAL_W-1:0] box_min_z,
    input  logic signed [VAL_W-1:0] box_max_x,
    input  logic signed [VAL_W-1:0] box_max_y,
    input  logic signed [VAL_W-1:0] box_max_z,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    visible
);

    state_t                  state_reg;
    state_t                  state_next;
    logic [PLANE_W-1:0]      plane_reg;
    logic [PLANE_W-1:0]      plane_next;
    logic [AXIS_W-1:0]       axis_reg;
    logic [AXIS_W-1:0]       axis_next;
    logic [IDX_W-1:0]        col_reg;
    logic [IDX_W-1:0]        col_next;
    logic                    fail_reg;
    logic                    fail_next;
    logic                    result_reg;
    logic                    result_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    visible_reg;
    logic                    visible_next;
    logic signed [VAL_W-1:0] box_min_reg  [N_AXES];
    logic signed [VAL_W-1:0] box_min_next [N_AXES];
    logic signed [VAL_W-1:0] box_max_reg  [N_AXES];
    logic signed [VAL_W-1:0] box_max_next [N_AXES];

    logic                     in_accept;
    logic                     out_accept;
    mac_ctrl_t                mac_ctrl;
    store_ctrl_t              store_ctrl;
    logic signed [COEF_W-1:0] coef;
    logic signed [VAL_W-1:0]  corner;
    logic signed [VAL_W-1:0]  sel_min;
    logic signed [VAL_W-1:0]  sel_max;
    logic                     acc_neg;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // box corner for the current axis: max if normal component >= 0
    always_comb
    begin
        unique case (axis_reg)
            STEP_Y:
            begin
                sel_min = box_min_reg[1];
                sel_max = box_max_reg[1];
            end
            STEP_Z:
            begin
                sel_min = box_min_reg[2];
                sel_max = box_max_reg[2];
            end
            default:
            begin
                sel_min = box_min_reg[0];
                sel_max = box_max_reg[0];
            end
        endcase
        corner = coef[COEF_W-1] ? sel_min : sel_max;
    end

    // sequencer: next state and unit controls
    always_comb
    begin
        state_next     = state_reg;
        plane_next     = plane_reg;
        axis_next      = axis_reg;
        col_next       = col_reg;
        fail_next      = fail_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_accept;
        visible_next   = visible_reg;
        box_min_next   = box_min_reg;
        box_max_next   = box_max_reg;
        mac_ctrl       = '{acc_op: ACC_HOLD, prod_d: 1'b0};
        store_ctrl     = '{mat_we: 1'b0, plane_we: 1'b0, rebuild_col: col_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    plane_next      = '0;
                    axis_next       = STEP_X;
                    col_next        = '0;
                    fail_next       = 1'b0;
                    result_next     = 1'b0;
                    box_min_next[0] = box_min_x;
                    box_min_next[1] = box_min_y;
                    box_min_next[2] = box_min_z;
                    box_max_next[0] = box_max_x;
                    box_max_next[1] = box_max_y;
                    box_max_next[2] = box_max_z;
                    unique case (func)
                        FUNC_LOAD:
                        begin
                            store_ctrl.mat_we = 1'b1;
                            state_next        = ST_DONE;
                        end
                        FUNC_REBUILD: state_next = ST_REBUILD;
                        FUNC_TEST:    state_next = ST_TEST;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end

            ST_REBUILD:
            begin
                store_ctrl.plane_we = 1'b1;
                col_next            = col_reg + 1'b1;
                if (col_reg == LAST_COL)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_TEST:
            begin
                unique case (axis_reg)
                    STEP_X:
                    begin
                        // accumulator holds the previous plane's distance here
                        if ((plane_reg != '0) && acc_neg)
                        begin
                            fail_next = 1'b1;
                        end
                    end
                    STEP_Y:   mac_ctrl.acc_op = ACC_LOAD;
                    STEP_Z:   mac_ctrl.acc_op = ACC_ADD;
                    STEP_D:
                    begin
                        mac_ctrl.acc_op = ACC_ADD;
                        mac_ctrl.prod_d = 1'b1;
                    end
                    default:  mac_ctrl.acc_op = ACC_ADD;
                endcase

                if (axis_reg == STEP_LAST)
                begin
                    axis_next  = STEP_X;
                    plane_next = plane_reg + 1'b1;
                    if (plane_reg == LAST_PLANE)
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end

            ST_FINISH:
            begin
                result_next = !(fail_reg || acc_neg);
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    visible_next   = result_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plane_reg     <= '0;
            axis_reg      <= STEP_X;
            col_reg       <= '0;
            fail_reg      <= 1'b0;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plane_reg     <= plane_next;
            axis_reg      <= axis_next;
            col_reg       <= col_next;
            fail_reg      <= fail_next;
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
        box_min_reg <= box_min_next;
        box_max_reg <= box_max_next;
    end

    fbc_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (store_ctrl),
        .mat_col    (matrix_column),
        .mat_row    (matrix_row),
        .mat_value  (matrix_value),
        .coef_plane (plane_reg),
        .coef_index (axis_reg[IDX_W-1:0]),
        .coef       (coef)
    );

    fbc_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef    (coef),
        .corner  (corner),
        .acc_neg (acc_neg)
    );

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

endmodule

`default_nettype wire

// ----- rtl/fbc_mac.sv -----
`default_nettype none

module fbc_mac
    import fbc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [VAL_W-1:0]  corner,
    output logic                     acc_neg
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // product stage: one multiply or the d term each cycle
    always_comb
    begin
        if (ctrl.prod_d)
        begin
            prod_next = PROD_W'(coef) <<< FRAC_W;
        end
        else
        begin
            prod_next = PROD_W'(coef) * PROD_W'(corner);
        end
    end

    // accumulate stage
    always_comb
    begin
        unique case (ctrl.acc_op)
            ACC_LOAD: acc_next = ACC_W'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc_neg = acc_reg[ACC_W-1];

endmodule

`default_nettype wire

// ----- rtl/fbc_store.sv -----
`default_nettype none

module fbc_store
    import fbc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  store_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]         mat_col,
    input  logic [IDX_W-1:0]         mat_row,
    input  logic signed [VAL_W-1:0]  mat_value,
    input  logic [PLANE_W-1:0]       coef_plane,
    input  logic [IDX_W-1:0]         coef_index,
    output logic signed [COEF_W-1:0] coef
);

    logic signed [VAL_W-1:0]  mat_reg   [N_DIM][N_DIM];      // [column][row]
    logic signed [COEF_W-1:0] plane_reg [N_PLANES][N_COEF];  // nx, ny, nz, d
    logic signed [COEF_W-1:0] col_w;
    logic signed [COEF_W-1:0] col_e     [N_PLANES];
    logic signed [COEF_W-1:0] plane_col [N_PLANES];

    // one matrix column per rebuild cycle: row 3 plus or minus row p/2
    always_comb
    begin
        col_w = COEF_W'(mat_reg[ctrl.rebuild_col][W_ROW]);
        for (int p = 0; p < N_PLANES; p++)
        begin
            col_e[p] = COEF_W'(mat_reg[ctrl.rebuild_col][IDX_W'(p / 2)]);
            if ((p % 2) == 0)
            begin
                plane_col[p] = col_w + col_e[p];
            end
            else
            begin
                plane_col[p] = col_w - col_e[p];
            end
        end
    end

    // matrix writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < N_DIM; c++)
            begin
                for (int r = 0; r < N_DIM; r++)
                begin
                    mat_reg[c][r] <= '0;
                end
            end
        end
        else if (ctrl.mat_we)
        begin
            mat_reg[mat_col][mat_row] <= mat_value;
        end
    end

    // plane writes, one coefficient of every plane per cycle while plane_we is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < N_PLANES; p++)
            begin
                for (int j = 0; j < N_COEF; j++)
                begin
                    plane_reg[p][j] <= '0;
                end
            end
        end
        else if (ctrl.plane_we)
        begin
            for (int p = 0; p < N_PLANES; p++)
            begin
                plane_reg[p][ctrl.rebuild_col] <= plane_col[p];
            end
        end
    end

    assign coef = plane_reg[coef_plane][coef_index];

endmodule

`default_nettype wire

// ----- rtl/fbc_checker.sv -----
`default_nettype none

module fbc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic visible
);

    // every accepted command leaves the block busy in the cycle after it
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input taken on two consecutive cycles");

    // a new result appears only as the block returns to accepting commands
    a_result_frees_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall
    ) else $error("result shown while block still busy");

    // a stalled output beat holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(visible))
    ) else $error("stalled output beat changed");

endmodule

bind frustum_box_cull_top fbc_checker u_fbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .visible   (visible)
);

`default_nettype wire

// ----- bench/frustum_box_cull_checker.sv -----
`default_nettype none

module frustum_box_cull_checker
    import fbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [1:0]              func,
    input  logic [IDX_W-1:0]        matrix_column,
    input  logic [IDX_W-1:0]        matrix_row,
    input  logic signed [VAL_W-1:0] matrix_value,
    input  logic signed [VAL_W-1:0] box_min_x,
    input  logic signed [VAL_W-1:0] box_min_y,
    input  logic signed [VAL_W-1:0] box_min_z,
    input  logic signed [VAL_W-1:0] box_max_x,
    input  logic signed [VAL_W-1:0] box_max_y,
    input  logic signed [VAL_W-1:0] box_max_z,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    visible,
    output int                      mismatch_count,
    output int                      pending_count
);

    // wide enough for three exact products plus the scaled d term
    localparam int unsigned DIST_W = 96;

    logic signed [VAL_W-1:0]  view_mat   [N_DIM*N_DIM];
    logic signed [COEF_W-1:0] plane_coef [N_PLANES*N_COEF];
    bit                       visible_queue [$];
    int                       errors;
    bit                       exp_visible;

    // planes from the matrix: row 3 plus or minus row k, column by column
    function automatic void rebuild_planes();
        logic signed [COEF_W-1:0] w_term;
        logic signed [COEF_W-1:0] e_term;
        for (int p = 0; p < N_PLANES; p++)
        begin
            for (int j = 0; j < N_COEF; j++)
            begin
                w_term = view_mat[j*N_DIM + 3];
                e_term = view_mat[j*N_DIM + p/2];
                if (p % 2)
                    plane_coef[p*N_COEF + j] = w_term - e_term;
                else
                    plane_coef[p*N_COEF + j] = w_term + e_term;
            end
        end
    endfunction

    // exact signed distance of the furthest corner, per plane
    function automatic bit box_in_frustum(
        input logic signed [VAL_W-1:0] min_x,
        input logic signed [VAL_W-1:0] min_y,
        input logic signed [VAL_W-1:0] min_z,
        input logic signed [VAL_W-1:0] max_x,
        input logic signed [VAL_W-1:0] max_y,
        input logic signed [VAL_W-1:0] max_z
    );
        logic signed [VAL_W-1:0]  lo_pt [N_AXES];
        logic signed [VAL_W-1:0]  hi_pt [N_AXES];
        logic signed [DIST_W-1:0] distance;
        logic signed [DIST_W-1:0] coef_w;
        logic signed [DIST_W-1:0] pt_w;
        lo_pt[0] = min_x;
        lo_pt[1] = min_y;
        lo_pt[2] = min_z;
        hi_pt[0] = max_x;
        hi_pt[1] = max_y;
        hi_pt[2] = max_z;
        for (int p = 0; p < N_PLANES; p++)
        begin
            distance = '0;
            for (int a = 0; a < N_AXES; a++)
            begin
                coef_w = plane_coef[p*N_COEF + a];
                if (coef_w >= 0)
                    pt_w = hi_pt[a];
                else
                    pt_w = lo_pt[a];
                distance = distance + coef_w * pt_w;
            end
            coef_w = plane_coef[p*N_COEF + 3];
            distance = distance + (coef_w <<< FRAC_W);
            if (distance < 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // compare result beats, then predict from command beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (view_mat[i])
                view_mat[i] = '0;
            foreach (plane_coef[i])
                plane_coef[i] = '0;
            visible_queue.delete();
            errors = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (visible_queue.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, visible=%0b",
                             $time, visible);
                    errors++;
                end
                else
                begin
                    exp_visible = visible_queue.pop_front();
                    if (visible !== exp_visible)
                    begin
                        $display("%0t: visible mismatch, expected %0b, got %0b",
                                 $time, exp_visible, visible);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                case (func)
                    FUNC_LOAD:
                    begin
                        view_mat[matrix_column*N_DIM + matrix_row] = matrix_value;
                        visible_queue.push_back(1'b0);
                    end
                    FUNC_REBUILD:
                    begin
                        rebuild_planes();
                        visible_queue.push_back(1'b0);
                    end
                    FUNC_TEST:
                        visible_queue.push_back(box_in_frustum(box_min_x, box_min_y,
                            box_min_z, box_max_x, box_max_y, box_max_z));
                    default:
                        visible_queue.push_back(1'b0);
                endcase
            end
            mismatch_count <= errors;
            pending_count  <= visible_queue.size();
        end
    end

endmodule

`default_nettype wire

// ----- bench/frustum_box_cull_top_tb.sv -----
`default_nettype none

module frustum_box_cull_top_tb;
    import fbc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 600;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic [1:0]              func;
        logic [IDX_W-1:0]        column;
        logic [IDX_W-1:0]        row;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] min_x;
        logic signed [VAL_W-1:0] min_y;
        logic signed [VAL_W-1:0] min_z;
        logic signed [VAL_W-1:0] max_x;
        logic signed [VAL_W-1:0] max_y;
        logic signed [VAL_W-1:0] max_z;
    } command_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              func = '0;
    logic [IDX_W-1:0]        matrix_column = '0;
    logic [IDX_W-1:0]        matrix_row = '0;
    logic signed [VAL_W-1:0] matrix_value = '0;
    logic signed [VAL_W-1:0] box_min_x = '0;
    logic signed [VAL_W-1:0] box_min_y = '0;
    logic signed [VAL_W-1:0] box_min_z = '0;
    logic signed [VAL_W-1:0] box_max_x = '0;
    logic signed [VAL_W-1:0] box_max_y = '0;
    logic signed [VAL_W-1:0] box_max_z = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    visible;

    int mismatch_count;
    int pending_count;
    int cycle_count = 0;
    int beats_sent = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    frustum_box_cull_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .matrix_column (matrix_column),
        .matrix_row    (matrix_row),
        .matrix_value  (matrix_value),
        .box_min_x     (box_min_x),
        .box_min_y     (box_min_y),
        .box_min_z     (box_min_z),
        .box_max_x     (box_max_x),
        .box_max_y     (box_max_y),
        .box_max_z     (box_max_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .visible       (visible)
    );

    frustum_box_cull_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .matrix_column  (matrix_column),
        .matrix_row     (matrix_row),
        .matrix_value   (matrix_value),
        .box_min_x      (box_min_x),
        .box_min_y      (box_min_y),
        .box_min_z      (box_min_z),
        .box_max_x      (box_max_x),
        .box_max_y      (box_max_y),
        .box_max_z      (box_max_z),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .visible        (visible),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // result side stalls in short bursts, none while calm
    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            stall_left <= $urandom_range(0, 4);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // every field random; each command overrides what it uses
    function automatic command_t random_fill(input logic [1:0] code);
        command_t c;
        c.func   = code;
        c.column = IDX_W'($urandom_range(0, 3));
        c.row    = IDX_W'($urandom_range(0, 3));
        c.value  = $urandom;
        c.min_x  = $urandom;
        c.min_y  = $urandom;
        c.min_z  = $urandom;
        c.max_x  = $urandom;
        c.max_y  = $urandom;
        c.max_z  = $urandom;
        return c;
    endfunction

    function automatic command_t load_cmd(input int col, input int row,
                                          input logic signed [VAL_W-1:0] val);
        command_t c;
        c        = random_fill(FUNC_LOAD);
        c.column = IDX_W'(col);
        c.row    = IDX_W'(row);
        c.value  = val;
        return c;
    endfunction

    function automatic command_t test_cmd(
        input logic signed [VAL_W-1:0] lx, input logic signed [VAL_W-1:0] ly,
        input logic signed [VAL_W-1:0] lz, input logic signed [VAL_W-1:0] hx,
        input logic signed [VAL_W-1:0] hy, input logic signed [VAL_W-1:0] hz);
        command_t c;
        c       = random_fill(FUNC_TEST);
        c.min_x = lx;
        c.min_y = ly;
        c.min_z = lz;
        c.max_x = hx;
        c.max_y = hy;
        c.max_z = hz;
        return c;
    endfunction

    function automatic logic signed [VAL_W-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return -32'sd1;
            default: return Q_ONE;
        endcase
    endfunction

    // matrix entries mostly within +-4.0
    function automatic logic signed [VAL_W-1:0] matrix_entry();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return int'($urandom_range(0, 524288)) - 262144;
        else if (pick < 85)
            return int'($urandom_range(0, 2048)) - 1024;
        else if (pick < 93)
            return $urandom;
        else
            return extreme_value();
    endfunction

    // box coordinates mostly within +-64.0
    function automatic logic signed [VAL_W-1:0] box_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return int'($urandom_range(0, 8388608)) - 4194304;
        else if (pick < 80)
            return int'($urandom_range(0, 262144)) - 131072;
        else if (pick < 92)
            return $urandom;
        else
            return extreme_value();
    endfunction

    // sorted corners per axis, now and then inverted
    function automatic command_t random_box();
        logic signed [VAL_W-1:0] a [N_AXES];
        logic signed [VAL_W-1:0] b [N_AXES];
        logic signed [VAL_W-1:0] t;
        bit flip;
        flip = ($urandom_range(0, 99) < 10);
        for (int i = 0; i < N_AXES; i++)
        begin
            a[i] = box_coord();
            b[i] = box_coord();
            if ((a[i] > b[i]) != flip)
            begin
                t    = a[i];
                a[i] = b[i];
                b[i] = t;
            end
        end
        return test_cmd(a[0], a[1], a[2], b[0], b[1], b[2]);
    endfunction

    // perspective-like entry, or a free one
    function automatic logic signed [VAL_W-1:0] frustum_entry(input bit shaped,
                                                              input int col,
                                                              input int row);
        if (!shaped)
            return matrix_entry();
        if (col == row && col < 3)
            return int'($urandom_range(32768, 196608));
        if (col == 2 && row == 3)
            return -Q_ONE;
        if (col == 3 && row == 2)
            return -int'($urandom_range(32768, 131072));
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 16384)) - 8192;
        return '0;
    endfunction

    // one command beat, held until accepted, then maybe a gap
    task automatic send_command(input command_t c);
        func          <= c.func;
        matrix_column <= c.column;
        matrix_row    <= c.row;
        matrix_value  <= c.value;
        box_min_x     <= c.min_x;
        box_min_y     <= c.min_y;
        box_min_z     <= c.min_z;
        box_max_x     <= c.max_x;
        box_max_y     <= c.max_y;
        box_max_z     <= c.max_z;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        if (!calm && $urandom_range(0, 99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // hold off until every result has come back
    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    initial
    begin
        int pick;
        int start_beats;
        int cnt;
        bit shaped;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero planes, unused code, loads around rebuilds
        send_command(test_cmd(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_command(random_fill(FUNC_UNUSED));
        send_command(load_cmd(3, 3, Q_MAX));
        send_command(load_cmd(0, 0, Q_MIN));
        send_command(load_cmd(1, 1, Q_ONE));
        send_command(load_cmd(2, 2, -Q_ONE));
        send_command(test_cmd(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_command(random_fill(FUNC_REBUILD));
        send_command(test_cmd(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_command(test_cmd(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_command(test_cmd('0, '0, '0, '0, '0, '0));
        send_command(test_cmd(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_command(load_cmd(3, 0, Q_MIN));
        send_command(test_cmd('0, '0, '0, '0, '0, '0));
        send_command(random_fill(FUNC_REBUILD));
        send_command(test_cmd(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        // zero normals: only d decides
        send_command(load_cmd(0, 0, '0));
        send_command(load_cmd(1, 1, '0));
        send_command(load_cmd(2, 2, '0));
        send_command(random_fill(FUNC_REBUILD));
        send_command(test_cmd(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_command(load_cmd(3, 0, '0));
        send_command(random_fill(FUNC_REBUILD));
        send_command(test_cmd(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        wait_results();

        // random: matrix loads, rebuilds and runs of box tests
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS)
        begin
            calm = (beats_sent - start_beats >= 250) && (beats_sent - start_beats < 380);
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                shaped = $urandom_range(0, 1);
                for (int col = 0; col < N_DIM; col++)
                    for (int row = 0; row < N_DIM; row++)
                        send_command(load_cmd(col, row, frustum_entry(shaped, col, row)));
                send_command(random_fill(FUNC_REBUILD));
            end
            else if (pick < 25)
            begin
                cnt = $urandom_range(1, 4);
                repeat (cnt)
                    send_command(load_cmd($urandom_range(0, 3), $urandom_range(0, 3),
                                          matrix_entry()));
                if ($urandom_range(0, 1))
                    send_command(random_fill(FUNC_REBUILD));
            end
            else if (pick < 30)
                send_command(random_fill(FUNC_UNUSED));
            else if (pick < 32)
                wait_results();
            else
            begin
                cnt = $urandom_range(1, 6);
                repeat (cnt)
                    send_command(random_box());
            end
        end
        calm = 1'b0;

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/fbc_pkg.sv
rtl/fbc_mac.sv
rtl/fbc_store.sv
rtl/frustum_box_cull_top.sv
rtl/fbc_checker.sv
bench/frustum_box_cull_checker.sv
bench/frustum_box_cull_top_tb.sv
